FILE: src/ffa_pkg.sv
`default_nettype none

package ffa_pkg;

   // operation codes of a request word
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ZERO     = 3'd1;
   localparam logic [2:0] ST_OOM      = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // configuration register indexes
   localparam logic CSR_PAGE_BYTES  = 1'b0;
   localparam logic CSR_ARENA_LIMIT = 1'b1;

   localparam int CSR_DATA_W = 21;

   typedef struct packed {
      logic        opcode;
      logic [20:0] request_bytes;
      logic [19:0] release_address;
   } req_word_type;

   typedef struct packed {
      logic [19:0] payload_address;
      logic [2:0]  status;
   } rsp_word_type;

   // table write kinds
   typedef enum logic [2:0] {
      WR_NONE,
      WR_TAKE,
      WR_MARK_FREE,
      WR_SPLIT_HEAD,
      WR_SPLIT_TAIL,
      WR_GROW_LINK,
      WR_GROW_NEW
   } wr_kind_type;

   // where the result address comes from
   typedef enum logic [1:0] {
      RES_NONE,
      RES_ZERO,
      RES_ENTRY,
      RES_TOP
   } res_src_type;

   typedef struct packed {
      logic        load;
      logic        read;
      logic        advance;
      wr_kind_type wr_kind;
      res_src_type res_src;
      logic [2:0]  res_status;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic is_free_op;
      logic zero_req;
      logic walk_end;
      logic table_full;
      logic out_of_mem;
      logic has_prev;
      logic fit_exact;
      logic fit_split;
      logic addr_match;
      logic out_busy;
   } stat_type;

endpackage

`default_nettype wire

FILE: src/ffa_ram.sv
`default_nettype none

module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/ffa_ctrl.sv
`default_nettype none

module ffa_ctrl
   import ffa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_WALK  = 7'b0000010,
      S_EVAL  = 7'b0000100,
      S_SPLIT = 7'b0001000,
      S_LINK  = 7'b0010000,
      S_GROW  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (!stat.is_free_op && stat.zero_req) begin
               cmd.res_src = RES_ZERO;
               cmd.res_status = ST_ZERO;
               state_in = S_RESP;
            end else if (stat.walk_end) begin
               if (stat.is_free_op) begin
                  cmd.res_src = RES_ZERO;
                  cmd.res_status = ST_NOTFOUND;
                  state_in = S_RESP;
               end else if (stat.table_full) begin
                  cmd.res_src = RES_ZERO;
                  cmd.res_status = ST_FULL;
                  state_in = S_RESP;
               end else if (stat.out_of_mem) begin
                  cmd.res_src = RES_ZERO;
                  cmd.res_status = ST_OOM;
                  state_in = S_RESP;
               end else if (stat.has_prev) begin
                  state_in = S_LINK;
               end else begin
                  state_in = S_GROW;
               end
            end else begin
               cmd.read = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.is_free_op) begin
               if (stat.addr_match) begin
                  cmd.wr_kind = WR_MARK_FREE;
                  cmd.res_src = RES_ZERO;
                  cmd.res_status = ST_OK;
                  state_in = S_RESP;
               end else begin
                  cmd.advance = 1'b1;
                  state_in = S_WALK;
               end
            end else if (stat.fit_exact) begin
               cmd.wr_kind = WR_TAKE;
               cmd.res_src = RES_ENTRY;
               cmd.res_status = ST_OK;
               state_in = S_RESP;
            end else if (stat.fit_split) begin
               cmd.res_src = RES_ENTRY;
               cmd.res_status = ST_OK;
               if (stat.table_full) begin
                  cmd.wr_kind = WR_TAKE;
                  state_in = S_RESP;
               end else begin
                  cmd.wr_kind = WR_SPLIT_HEAD;
                  state_in = S_SPLIT;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in = S_WALK;
            end
         end
         S_SPLIT: begin
            cmd.wr_kind = WR_SPLIT_TAIL;
            state_in = S_RESP;
         end
         S_LINK: begin
            cmd.wr_kind = WR_GROW_LINK;
            state_in = S_GROW;
         end
         S_GROW: begin
            cmd.wr_kind = WR_GROW_NEW;
            cmd.res_src = RES_TOP;
            cmd.res_status = ST_OK;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_WALK)
      else $error("accepted word did not start a walk");

   a_write_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_kind != WR_NONE |-> req_stall)
      else $error("table write while idle");

   a_split_follows_head: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_kind == WR_SPLIT_TAIL |-> $past(cmd.wr_kind) == WR_SPLIT_HEAD)
      else $error("split tail without split head");

endmodule

`default_nettype wire

FILE: src/ffa_datapath.sv
`default_nettype none

module ffa_datapath
   import ffa_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int WORD_BYTES   = 8,
   parameter int HEADER_BYTES = 24,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_word_type          req_word,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output rsp_word_type               rsp_word
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int LINK_W = IDX_W + 1;
   localparam int BYTE_W = ADDR_BITS + 1;
   localparam int REC_W  = ADDR_BITS + BYTE_W + 1 + LINK_W;
   localparam int BASE_W = (ADDR_BITS + 1 > 22) ? ADDR_BITS + 1 : 22;
   localparam int CALC_W = BASE_W + 2;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);
   localparam logic [CALC_W-1:0] HDR = CALC_W'(HEADER_BYTES);
   localparam logic [CALC_W-1:0] WORD = CALC_W'(WORD_BYTES);
   localparam logic [CALC_W-1:0] CAP = CALC_W'(1) << ADDR_BITS;

   typedef struct packed {
      logic [ADDR_BITS-1:0] off;
      logic [BYTE_W-1:0]    bytes;
      logic                 free;
      logic [LINK_W-1:0]    next;
   } rec_type;

   logic                  op_ff;
   logic [20:0]           req_ff;
   logic [19:0]           rel_ff;
   logic [CALC_W-1:0]     size_ff, size_in;
   logic [LINK_W-1:0]     cur_ff, prev_ff, head_ff, used_ff;
   logic [LINK_W-1:0]     steps_ff;
   logic [ADDR_BITS:0]    top_ff;
   logic [16:0]           page_ff;
   logic [20:0]           limit_ff;
   rec_type               rec_ff;
   logic                  eval_ff;
   logic [19:0]           res_addr_ff;
   logic [2:0]            res_st_ff;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   rec_type               ent;
   logic [REC_W-1:0]      rd_data;
   rec_type               wr_rec;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_en;
   logic [CALC_W-1:0]     grow, newtop, lim_eff, ent_bytes, addr_calc;

   assign ent = rec_type'(rd_data);

   // rounded request size
   assign size_in = ((CALC_W'(req_word.request_bytes) + WORD - CALC_W'(1)) / WORD) * WORD;

   assign ent_bytes = CALC_W'(ent.bytes);
   assign grow = (size_ff > CALC_W'(page_ff)) ? size_ff : CALC_W'(page_ff);
   assign newtop = CALC_W'(top_ff) + HDR + grow;
   assign lim_eff = (CALC_W'(limit_ff) < CAP) ? CALC_W'(limit_ff) : CAP;

   always_comb begin
      stat.is_free_op = (op_ff == OP_FREE);
      stat.zero_req   = (req_ff == '0);
      stat.walk_end   = !(cur_ff < used_ff) || (steps_ff == LINK_W'(MAX_BLOCKS));
      stat.table_full = (used_ff >= LINK_W'(MAX_BLOCKS));
      stat.out_of_mem = (newtop > lim_eff);
      stat.has_prev   = (prev_ff != NIL);
      stat.fit_exact  = ent.free && (ent_bytes == size_ff);
      stat.fit_split  = ent.free && (ent_bytes > size_ff) && (ent_bytes >= size_ff + HDR);
      stat.addr_match = (CALC_W'(ent.off) + HDR) == CALC_W'(rel_ff);
      stat.out_busy   = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      wr_en = 1'b1;
      wr_addr = cur_ff[IDX_W-1:0];
      wr_rec = ent;
      case (cmd.wr_kind)
         WR_TAKE: begin
            wr_rec.free = 1'b0;
         end
         WR_MARK_FREE: begin
            wr_rec.free = 1'b1;
         end
         WR_SPLIT_HEAD: begin
            wr_rec.bytes = size_ff[BYTE_W-1:0];
            wr_rec.free = 1'b0;
            wr_rec.next = used_ff;
         end
         WR_SPLIT_TAIL: begin
            wr_addr = used_ff[IDX_W-1:0];
            wr_rec.off = ADDR_BITS'(CALC_W'(rec_ff.off) + HDR + size_ff);
            wr_rec.bytes = BYTE_W'(CALC_W'(rec_ff.bytes) - size_ff - HDR);
            wr_rec.free = 1'b1;
            wr_rec.next = rec_ff.next;
         end
         WR_GROW_LINK: begin
            wr_addr = prev_ff[IDX_W-1:0];
            wr_rec = rec_ff;
            wr_rec.next = used_ff;
         end
         WR_GROW_NEW: begin
            wr_addr = used_ff[IDX_W-1:0];
            wr_rec.off = top_ff[ADDR_BITS-1:0];
            wr_rec.bytes = grow[BYTE_W-1:0];
            wr_rec.free = 1'b0;
            wr_rec.next = NIL;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cmd.res_src)
         RES_ENTRY: addr_calc = CALC_W'(ent.off) + HDR;
         RES_TOP:   addr_calc = CALC_W'(top_ff) + HDR;
         default:   addr_calc = '0;
      endcase
   end

   ffa_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (cmd.read),
      .rd_addr (cur_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // walk registers and payload
   always_ff @(posedge clock) begin
      eval_ff <= cmd.read;
      if (eval_ff) begin
         rec_ff <= ent;
      end
      if (cmd.load) begin
         op_ff <= req_word.opcode;
         req_ff <= req_word.request_bytes;
         rel_ff <= req_word.release_address;
         size_ff <= size_in;
         cur_ff <= head_ff;
         prev_ff <= NIL;
         steps_ff <= '0;
      end else if (cmd.advance) begin
         prev_ff <= cur_ff;
         cur_ff <= ent.next;
         steps_ff <= steps_ff + LINK_W'(1);
      end
      if (cmd.res_src != RES_NONE) begin
         res_addr_ff <= addr_calc[19:0];
         res_st_ff <= cmd.res_status;
      end
      if (cmd.out_load) begin
         rsp_word_ff.payload_address <= res_addr_ff;
         rsp_word_ff.status <= res_st_ff;
      end
   end

   // allocator state, configuration and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL;
         used_ff <= '0;
         top_ff <= '0;
         page_ff <= 17'd4096;
         limit_ff <= 21'd1048576;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAGE_BYTES:  page_ff <= csr_data[16:0];
               CSR_ARENA_LIMIT: limit_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.wr_kind == WR_SPLIT_TAIL) begin
            used_ff <= used_ff + LINK_W'(1);
         end
         if (cmd.wr_kind == WR_GROW_NEW) begin
            used_ff <= used_ff + LINK_W'(1);
            top_ff <= newtop[ADDR_BITS:0];
            if (prev_ff == NIL) begin
               head_ff <= used_ff;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LINK_W'(MAX_BLOCKS))
      else $error("entry count past table depth");

   a_used_steps: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (used_ff == $past(used_ff) || used_ff == $past(used_ff) + LINK_W'(1)))
      else $error("entry count jumped");

   a_top_bounded: assert property (@(posedge clock) disable iff (reset)
      CALC_W'(top_ff) <= CAP)
      else $error("heap top past address space");

endmodule

`default_nettype wire

FILE: src/first_fit_block_allocator.sv
// a zero size responds without a walk; a hit walks to a free entry that fits, a split then
// writes the tail entry; a miss ends in an error status or a heap extension, linked onto a
// previous entry when there is one; the response waits while the response word stalls
// one request at a time; the next is taken in the cycle after the response word loads
// reset: synchronous active-high reset empties the list, zeroes the heap top and entry
// count and restores page_bytes 4096 and arena_limit_bytes 1048576; the table is not cleared
`default_nettype none

module first_fit_block_allocator
   import ffa_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int WORD_BYTES   = 8,
   parameter int HEADER_BYTES = 24,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request word channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_word_type          req_word,
   // response word channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_word_type               rsp_word,
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // registers are to be written only while idle; the block does not enforce this, so writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: walk, evaluate, write back, respond
   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // block table, heap state and response register
   ffa_datapath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .WORD_BYTES   (WORD_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
